// File: rtl/chip8_pkg.sv
// Package for the CHIP-8 instruction execute block.
// Holds the beat structs, item kind and status codes and sizing constants.
// No dependencies.
`default_nettype none
package chip8_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int MEM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;

  localparam int ADDR_W = $clog2(MEM_BYTES);
  localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic [11:0] PROG_START = 12'h200;

  localparam logic [1:0] KIND_EXEC     = 2'd0;
  localparam logic [1:0] KIND_MEM_WR   = 2'd1;
  localparam logic [1:0] KIND_MEM_RD   = 2'd2;
  localparam logic [1:0] KIND_SCR_RD   = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd1;
  localparam logic [1:0] STATUS_BAD_OP   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] instr;
    logic [15:0] keys;
    logic [7:0]  rand_byte;
    logic [11:0] mem_addr;
    logic [7:0]  mem_wdata;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pc_out;
    logic [1:0]  status;
    logic        waiting;
    logic        redraw;
    logic [63:0] read_data;
    logic [7:0]  sound_level;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/chip8_instruction_execute.sv
// CHIP-8 instruction execute block: sequencer, register file, call stack,
// 4 KiB memory and 64x32 display. Depends on chip8_pkg.
`default_nettype none
//
//  Channel | Valid     | Stall     | Payload                      | Direction
//  input   | in_valid  | in_stall  | in_data  (in_item_t)         | into block
//  output  | out_valid | out_stall | out_data (out_item_t)        | out of block
//
// One item is worked on at a time; in_stall is high from acceptance until its
// result beat has been taken. Instructions read VX, then VY, then execute;
// those that set VF add a flag state, DXYN reads and writes each sprite row
// in turn, FX55 and FX33 write memory a byte at a time and FX65 reads then
// writes each register. Memory writes go straight to the result beat, and
// reads pass a wait state. The single register file and memory ports set this.
// Reset is synchronous and clears the display at once through per-row valid
// bits; the block is ready the cycle after.
module chip8_instruction_execute (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  chip8_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output chip8_pkg::out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RDX, S_RDY, S_EXEC, S_FLAG, S_DRAW_RD, S_DRAW_WR, S_BCD,
    S_STORE, S_LOAD_RD, S_LOAD_WR, S_RD_WAIT, S_DONE
  } state_t;

  state_t                       state;
  chip8_pkg::in_item_t          item;
  logic [7:0]                   vreg [16];
  logic [11:0]                  stack_mem [chip8_pkg::STACK_DEPTH];
  logic [chip8_pkg::SP_W-1:0]   sp;
  logic [11:0]                  pc;
  logic [11:0]                  ireg;
  logic [7:0]                   delay_cnt;
  logic [7:0]                   sound_cnt;
  logic [7:0]                   vx;
  logic [7:0]                   vy;
  logic [3:0]                   cnt;
  logic                         hit;
  logic [7:0]                   flag_val;
  logic [1:0]                   status;
  logic                         waiting;
  logic                         redraw;
  logic [63:0]                  rdata;
  logic [chip8_pkg::SCREEN_HEIGHT-1:0] row_valid;

  logic [7:0]  main_mem [chip8_pkg::MEM_BYTES];
  logic [63:0] screen [chip8_pkg::SCREEN_HEIGHT];
  logic        mem_we;
  logic [11:0] mem_waddr;
  logic [7:0]  mem_wd;
  logic [11:0] mem_raddr;
  logic [7:0]  mem_rdata;
  logic        scr_we;
  logic [chip8_pkg::ROW_W-1:0] scr_addr;
  logic [63:0] scr_wd;
  logic [63:0] scr_rdata;

  logic [3:0]  op_x;
  logic [3:0]  op_y;
  logic [3:0]  op_n;
  logic [7:0]  op_nn;
  logic [11:0] op_nnn;
  logic [11:0] cnt_addr;
  logic [chip8_pkg::ROW_W-1:0] draw_row;
  logic [63:0] row_now;
  logic [63:0] pat;
  logic [127:0] pat_dbl;
  logic [7:0]  sprite_rev;
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_rem;
  logic [14:0] bcd_prod;
  logic [3:0]  bcd_t;
  logic [3:0]  bcd_o;
  logic [3:0]  low_key;
  logic [chip8_pkg::SP_W-1:0] sp_inc;
  logic [chip8_pkg::SP_W-1:0] sp_dec;
  logic        accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign op_x     = item.instr[11:8];
  assign op_y     = item.instr[7:4];
  assign op_n     = item.instr[3:0];
  assign op_nn    = item.instr[7:0];
  assign op_nnn   = item.instr[11:0];
  assign cnt_addr = ireg + {8'd0, cnt};
  assign draw_row = vy[chip8_pkg::ROW_W-1:0] + {1'b0, cnt};
  assign row_now  = row_valid[scr_addr] ? scr_rdata : 64'd0;

  assign sp_inc = (sp == chip8_pkg::SP_W'(chip8_pkg::STACK_DEPTH - 1)) ?
                  '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ?
                  chip8_pkg::SP_W'(chip8_pkg::STACK_DEPTH - 1) : sp - 1'b1;

  // Sprite bit 7 is the leftmost pixel, which is column bit 0 of a row.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      sprite_rev[j] = mem_rdata[7-j];
    end
    pat_dbl = {56'd0, sprite_rev, 56'd0, sprite_rev} << vx[chip8_pkg::COL_W-1:0];
    pat     = pat_dbl[127:64];
  end

  // Decimal digits by compares and a reciprocal multiply (exact below 100).
  always_comb begin
    if (vx >= 8'd200) begin
      bcd_h = 2'd2;
    end else if (vx >= 8'd100) begin
      bcd_h = 2'd1;
    end else begin
      bcd_h = 2'd0;
    end
    bcd_rem  = 7'(vx - 8'(bcd_h) * 8'd100);
    bcd_prod = 15'(bcd_rem) * 15'd205;
    bcd_t    = bcd_prod[14:11];
    bcd_o    = 4'(bcd_rem - 7'(bcd_t) * 7'd10);
  end

  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (item.keys[k]) begin
        low_key = 4'(k);
      end
    end
  end

  // Memory and display port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_addr;
    mem_wd    = 8'd0;
    mem_raddr = cnt_addr;
    scr_we    = 1'b0;
    scr_addr  = draw_row;
    scr_wd    = row_now ^ pat;
    case (state)
      S_IDLE: begin
        mem_we    = accept && (in_data.kind == chip8_pkg::KIND_MEM_WR);
        mem_waddr = in_data.mem_addr;
        mem_wd    = in_data.mem_wdata;
        mem_raddr = in_data.mem_addr;
        scr_addr  = in_data.mem_addr[chip8_pkg::ROW_W-1:0];
      end
      S_RD_WAIT: begin
        scr_addr = item.mem_addr[chip8_pkg::ROW_W-1:0];
      end
      S_DRAW_WR: begin
        scr_we = 1'b1;
      end
      S_BCD: begin
        mem_we = 1'b1;
        case (cnt[1:0])
          2'd0:    mem_wd = {6'd0, bcd_h};
          2'd1:    mem_wd = {4'd0, bcd_t};
          default: mem_wd = {4'd0, bcd_o};
        endcase
      end
      S_STORE: begin
        mem_we = 1'b1;
        mem_wd = vreg[cnt];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      main_mem[mem_waddr] <= mem_wd;
    end
    mem_rdata <= main_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      screen[scr_addr] <= scr_wd;
    end
    scr_rdata <= screen[scr_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      pc        <= chip8_pkg::PROG_START;
      ireg      <= 12'd0;
      delay_cnt <= 8'd0;
      sound_cnt <= 8'd0;
      row_valid <= '0;
      for (int r = 0; r < 16; r++) begin
        vreg[r] <= 8'd0;
      end
    end else begin
      if (scr_we) begin
        row_valid[scr_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item    <= in_data;
            status  <= chip8_pkg::STATUS_OK;
            waiting <= 1'b0;
            redraw  <= 1'b0;
            rdata   <= 64'd0;
            cnt     <= 4'd0;
            hit     <= 1'b0;
            case (in_data.kind)
              chip8_pkg::KIND_EXEC:   state <= S_RDX;
              chip8_pkg::KIND_MEM_WR: state <= S_DONE;
              default:                state <= S_RD_WAIT;
            endcase
          end
        end
        S_RD_WAIT: begin
          if (item.kind == chip8_pkg::KIND_MEM_RD) begin
            rdata <= {56'd0, mem_rdata};
          end else if (item.mem_addr < 12'(chip8_pkg::SCREEN_HEIGHT)) begin
            rdata <= row_now;
          end
          state <= S_DONE;
        end
        S_RDX: begin
          vx    <= vreg[op_x];
          state <= S_RDY;
        end
        S_RDY: begin
          vy    <= (item.instr[15:12] == 4'hB) ? vreg[0] : vreg[op_y];
          state <= S_EXEC;
        end
        S_EXEC: begin
          pc    <= pc + 12'd2;
          state <= S_DONE;
          case (item.instr[15:12])
            4'h0: begin
              if (item.instr == 16'h00E0) begin
                row_valid <= '0;
                redraw    <= 1'b1;
              end else if (item.instr == 16'h00EE) begin
                sp <= sp_dec;
                pc <= stack_mem[sp_dec] + 12'd2;
              end else begin
                status <= chip8_pkg::STATUS_BAD_OP;
                pc     <= pc;
              end
            end
            4'h1, 4'h2: begin
              if (op_nnn < chip8_pkg::PROG_START) begin
                status <= chip8_pkg::STATUS_BAD_ADDR;
                pc     <= pc;
              end else begin
                pc <= op_nnn;
                if (item.instr[15:12] == 4'h2) begin
                  stack_mem[sp] <= pc;
                  sp            <= sp_inc;
                end
              end
            end
            4'h3: if (vx == op_nn) pc <= pc + 12'd4;
            4'h4: if (vx != op_nn) pc <= pc + 12'd4;
            4'h5: if (vx == vy) pc <= pc + 12'd4;
            4'h9: if (vx != vy) pc <= pc + 12'd4;
            4'h6: vreg[op_x] <= op_nn;
            4'h7: vreg[op_x] <= vx + op_nn;
            4'hC: vreg[op_x] <= item.rand_byte & op_nn;
            4'hA: ireg <= op_nnn;
            4'hB: pc <= op_nnn + {4'd0, vy};
            4'h8: begin
              case (op_n)
                4'h0: vreg[op_x] <= vy;
                4'h1: vreg[op_x] <= vx | vy;
                4'h2: vreg[op_x] <= vx & vy;
                4'h3: vreg[op_x] <= vx ^ vy;
                4'h4: begin
                  vreg[op_x] <= vx + vy;
                  flag_val   <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'h0FF};
                  state      <= S_FLAG;
                end
                4'h5: begin
                  vreg[op_x] <= vx - vy;
                  flag_val   <= {7'd0, vx >= vy};
                  state      <= S_FLAG;
                end
                4'h6: begin
                  vreg[op_x] <= {1'b0, vy[7:1]};
                  flag_val   <= {7'd0, vy[0]};
                  state      <= S_FLAG;
                end
                4'h7: begin
                  vreg[op_x] <= vy - vx;
                  flag_val   <= {7'd0, vy >= vx};
                  state      <= S_FLAG;
                end
                4'hE: begin
                  vreg[op_x] <= {vy[6:0], 1'b0};
                  flag_val   <= {7'd0, vy[7]};
                  state      <= S_FLAG;
                end
                default: begin
                  status <= chip8_pkg::STATUS_BAD_OP;
                  pc     <= pc;
                end
              endcase
            end
            4'hD: begin
              redraw   <= 1'b1;
              flag_val <= 8'd0;
              state    <= (op_n == 4'd0) ? S_FLAG : S_DRAW_RD;
            end
            4'hE: begin
              if (op_nn == 8'h9E) begin
                if (item.keys[vx[3:0]]) pc <= pc + 12'd4;
              end else if (op_nn == 8'hA1) begin
                if (!item.keys[vx[3:0]]) pc <= pc + 12'd4;
              end else begin
                status <= chip8_pkg::STATUS_BAD_OP;
                pc     <= pc;
              end
            end
            default: begin
              case (op_nn)
                8'h07: vreg[op_x] <= delay_cnt;
                8'h0A: begin
                  if (item.keys == 16'd0) begin
                    waiting <= 1'b1;
                    pc      <= pc;
                  end else begin
                    vreg[op_x] <= {4'd0, low_key};
                  end
                end
                8'h15: delay_cnt <= vx;
                8'h18: sound_cnt <= vx;
                8'h1E: begin
                  ireg     <= ireg + {4'd0, vx};
                  flag_val <= {7'd0, ({1'b0, ireg} + {5'd0, vx}) > 13'h0FFF};
                  state    <= S_FLAG;
                end
                8'h29: ireg <= ({4'd0, vx} << 2) + {4'd0, vx};
                8'h33: state <= S_BCD;
                8'h55: state <= S_STORE;
                8'h65: state <= S_LOAD_RD;
                default: begin
                  status <= chip8_pkg::STATUS_BAD_OP;
                  pc     <= pc;
                end
              endcase
            end
          endcase
        end
        S_FLAG: begin
          vreg[15] <= flag_val;
          state    <= S_DONE;
        end
        S_DRAW_RD: begin
          state <= S_DRAW_WR;
        end
        S_DRAW_WR: begin
          if ((row_now & pat) != 64'd0) begin
            hit <= 1'b1;
          end
          if (cnt == op_n - 4'd1) begin
            flag_val <= {7'd0, hit || ((row_now & pat) != 64'd0)};
            state    <= S_FLAG;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_DRAW_RD;
          end
        end
        S_BCD: begin
          if (cnt == 4'd2) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_STORE: begin
          if (cnt == op_x) begin
            ireg  <= ireg + {8'd0, op_x} + 12'd1;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_LOAD_RD: begin
          state <= S_LOAD_WR;
        end
        S_LOAD_WR: begin
          vreg[cnt] <= mem_rdata;
          if (cnt == op_x) begin
            ireg  <= ireg + {8'd0, op_x} + 12'd1;
            state <= S_DONE;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_LOAD_RD;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = (state == S_DONE);
  assign out_data.pc_out      = pc;
  assign out_data.status      = status;
  assign out_data.waiting     = waiting;
  assign out_data.redraw      = redraw;
  assign out_data.read_data   = rdata;
  assign out_data.sound_level = sound_cnt;

`ifndef NO_ASSERTIONS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result beat shown while a new item could be taken");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.kind != chip8_pkg::KIND_MEM_WR) |=> !out_valid)
    else $error("result beat in the cycle after acceptance");

  a_fault_no_draw: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != chip8_pkg::STATUS_OK) |-> !out_data.redraw)
    else $error("faulted instruction reports a redraw");

  a_wait_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.waiting) |-> (out_data.status == chip8_pkg::STATUS_OK))
    else $error("key wait reported with a fault status");
`endif

endmodule
`default_nettype wire
